// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the I2C master bit engine.
// No dependencies; the top level, i2cm_cfg and i2cm_seq refer to this package by scoped names.
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_A    = 4'd1,
    PH_S_B    = 4'd2,
    PH_P_A    = 4'd3,
    PH_P_B    = 4'd4,
    PH_W_D    = 4'd5,
    PH_W_H    = 4'd6,
    PH_W_L    = 4'd7,
    PH_A_R    = 4'd8,
    PH_A_POLL = 4'd9,
    PH_R_H    = 4'd10,
    PH_R_L    = 4'd11,
    PH_K_D    = 4'd12,
    PH_K_H    = 4'd13,
    PH_V_H    = 4'd14,
    PH_V_L    = 4'd15
  } phase_e;

  // Command codes carried in the request's func field
  localparam logic [2:0] FN_START    = 3'd0;
  localparam logic [2:0] FN_STOP     = 3'd1;
  localparam logic [2:0] FN_WRITE    = 3'd2;
  localparam logic [2:0] FN_WAIT_ACK = 3'd3;
  localparam logic [2:0] FN_READ     = 3'd4;
  localparam logic [2:0] FN_RECOVER  = 3'd5;

  // Register indexes (paddr[2])
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd1000;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd200;

  localparam logic [3:0] BITS_PER_BYTE    = 4'd8;
  localparam logic [3:0] RECOVERY_PULSES  = 4'd9;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] ack_timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] wr_byte;
    logic       ack_drive;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_fail;
  } result_t;

endpackage

// ===== design/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps
// I2C master bit engine top level: request/result stream registers around the sequencer.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_seq.
//
// Usage:
//   Each request on the s_axis channel is one timebase tick: tuser carries an
//   optional command (cmd_valid, func), tdata the write byte, the ACK choice
//   for a read and the sampled SDA level. Every request yields exactly one
//   result on the m_axis channel with the SCL/SDA drive levels, ready/done
//   status, the last read byte and the ACK failure flag.
//   A request is captured in an input register and then processed into the
//   result register, from which its result is shown on the m_axis channel.
//   One request per cycle is sustained while the result receiver does not
//   stall; the sequencer advances one tick per processed request.
//   When the result receiver stalls, the result register holds its value and
//   one more request is still taken into the input register before
//   s_axis_tready drops; nothing is lost or repeated.
//   Reset idles the sequencer with both lines released, empties both
//   registers and loads half_period_ticks = 1000 and ack_timeout_limit = 200.
//   Write the APB registers only while the engine is idle and drained.
module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: wr_byte[7:0], ack_drive[8], sda_in[9], zero [15:10]
  input  logic [15:0] s_axis_tdata,
  // tuser: cmd_valid[0], func[3:1]
  input  logic [3:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: scl_out[0], sda_out[1], ready_res[2], done_res[3], rd_data[11:4],
  //        ack_fail[12], zero [15:13]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::item_t   in_q, in_d;
  logic              in_valid_q, in_valid_d;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  logic              s_accept;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_d           = in_q;
    in_valid_d     = in_valid_q & ~advance;
    if (s_accept) begin
      in_d.cmd_valid = s_axis_tuser[0];
      in_d.func      = s_axis_tuser[3:1];
      in_d.wr_byte   = s_axis_tdata[7:0];
      in_d.ack_drive = s_axis_tdata[8];
      in_d.sda_in    = s_axis_tdata[9];
      in_valid_d     = 1'b1;
    end
  end

  always_comb begin
    out_d       = advance ? res : out_q;
    out_valid_d = advance | (out_valid_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  i2cm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.ack_fail, out_q.rd_data, out_q.done_res,
                          out_q.ready_res, out_q.sda_out, out_q.scl_out};

endmodule

// ===== design/i2cm_cfg.sv =====
`timescale 1ns / 1ps
// APB register file: half period and ACK timeout limit.
// Depends on i2cm_pkg for the register indexes, reset values and cfg_t.
module i2cm_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output i2cm_pkg::cfg_t     cfg_o
);

  logic [15:0] half_q, half_d;
  logic [15:0] tmo_q, tmo_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    half_d = half_q;
    tmo_d  = tmo_q;
    if (wr_en) begin
      case (paddr[2])
        i2cm_pkg::REG_HALF_PERIOD: half_d = pwdata[15:0];
        i2cm_pkg::REG_ACK_TIMEOUT: tmo_d  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cm_pkg::HALF_PERIOD_RESET;
      tmo_q  <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else begin
      half_q <= half_d;
      tmo_q  <= tmo_d;
    end
  end

  always_comb begin
    case (paddr[2])
      i2cm_pkg::REG_HALF_PERIOD: prdata = {16'h0000, half_q};
      i2cm_pkg::REG_ACK_TIMEOUT: prdata = {16'h0000, tmo_q};
      default:                   prdata = 32'h0000_0000;
    endcase
  end

  assign cfg_o.half_period_ticks = half_q;
  assign cfg_o.ack_timeout_limit = tmo_q;

endmodule

// ===== design/i2cm_seq.sv =====
`timescale 1ns / 1ps
// Bus sequencer: phase state, bit and delay counters, shift register and line levels.
// Advances one tick per step request. Depends on i2cm_pkg.
module i2cm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  i2cm_pkg::item_t     item_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::result_t   res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] delay_q, delay_d;
  logic [15:0] tmo_q, tmo_d;
  logic        ack_choice_q, ack_choice_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        nack_q, nack_d;
  logic [7:0]  rd_hold_q, rd_hold_d;
  logic        done_d;

  logic [15:0] reload;
  logic [3:0]  bit_inc;

  // A zero half period behaves as one tick
  assign reload  = (cfg_i.half_period_ticks == 16'd0) ? 16'd0
                                                     : cfg_i.half_period_ticks - 16'd1;
  assign bit_inc = bit_cnt_q + 4'd1;

  // Next state
  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    tmo_d        = tmo_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    nack_d       = nack_q;
    rd_hold_d    = rd_hold_q;
    done_d       = 1'b0;

    if (phase_q == i2cm_pkg::PH_IDLE) begin
      if (item_i.cmd_valid && (item_i.func <= i2cm_pkg::FN_RECOVER)) begin
        bit_cnt_d = 4'd0;
        delay_d   = reload;
        case (item_i.func)
          i2cm_pkg::FN_START: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_S_A;
          end
          i2cm_pkg::FN_STOP: begin
            scl_d = 1'b1; sda_d = 1'b0; phase_d = i2cm_pkg::PH_P_A;
          end
          i2cm_pkg::FN_WRITE: begin
            shift_d = {item_i.wr_byte[6:0], 1'b0};
            scl_d = 1'b0; sda_d = item_i.wr_byte[7]; phase_d = i2cm_pkg::PH_W_D;
          end
          i2cm_pkg::FN_WAIT_ACK: begin
            tmo_d = 16'd0;
            sda_d = 1'b1; phase_d = i2cm_pkg::PH_A_R;
          end
          i2cm_pkg::FN_READ: begin
            shift_d = 8'h00; ack_choice_d = item_i.ack_drive;
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_R_H;
          end
          default: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_V_H;
          end
        endcase
      end
    end else if (delay_q != 16'd0) begin
      delay_d = delay_q - 16'd1;
    end else begin
      case (phase_q)
        i2cm_pkg::PH_S_A: begin
          scl_d = 1'b1; sda_d = 1'b0; phase_d = i2cm_pkg::PH_S_B; delay_d = reload;
        end
        i2cm_pkg::PH_S_B: begin
          scl_d = 1'b0; phase_d = i2cm_pkg::PH_IDLE; done_d = 1'b1;
        end
        i2cm_pkg::PH_P_A: begin
          scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_P_B; delay_d = reload;
        end
        i2cm_pkg::PH_P_B: begin
          phase_d = i2cm_pkg::PH_IDLE; done_d = 1'b1;
        end
        i2cm_pkg::PH_W_D: begin
          scl_d = 1'b1; phase_d = i2cm_pkg::PH_W_H; delay_d = reload;
        end
        i2cm_pkg::PH_W_H: begin
          scl_d = 1'b0; phase_d = i2cm_pkg::PH_W_L; delay_d = reload;
        end
        i2cm_pkg::PH_W_L: begin
          bit_cnt_d = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            phase_d = i2cm_pkg::PH_IDLE; done_d = 1'b1;
          end else begin
            shift_d = {shift_q[6:0], 1'b0};
            scl_d = 1'b0; sda_d = shift_q[7]; phase_d = i2cm_pkg::PH_W_D; delay_d = reload;
          end
        end
        i2cm_pkg::PH_A_R: begin
          scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_A_POLL; delay_d = reload;
        end
        i2cm_pkg::PH_A_POLL: begin
          if (!item_i.sda_in) begin
            scl_d = 1'b0; nack_d = 1'b0; phase_d = i2cm_pkg::PH_IDLE; done_d = 1'b1;
          end else if (tmo_q >= cfg_i.ack_timeout_limit) begin
            // Timed out: flag NACK and run a stop
            nack_d = 1'b1;
            scl_d = 1'b1; sda_d = 1'b0; phase_d = i2cm_pkg::PH_P_A; delay_d = reload;
          end else begin
            tmo_d = tmo_q + 16'd1;
          end
        end
        i2cm_pkg::PH_R_H: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cm_pkg::PH_R_L; delay_d = reload;
        end
        i2cm_pkg::PH_R_L: begin
          bit_cnt_d = bit_inc;
          delay_d   = reload;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            scl_d = 1'b0; sda_d = ~ack_choice_q; phase_d = i2cm_pkg::PH_K_D;
          end else begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_R_H;
          end
        end
        i2cm_pkg::PH_K_D: begin
          scl_d = 1'b1; phase_d = i2cm_pkg::PH_K_H; delay_d = reload;
        end
        i2cm_pkg::PH_K_H: begin
          scl_d = 1'b0; rd_hold_d = shift_q; phase_d = i2cm_pkg::PH_IDLE; done_d = 1'b1;
        end
        i2cm_pkg::PH_V_H: begin
          scl_d = 1'b0; sda_d = 1'b1; phase_d = i2cm_pkg::PH_V_L; delay_d = reload;
        end
        i2cm_pkg::PH_V_L: begin
          bit_cnt_d = bit_inc;
          delay_d   = reload;
          if (bit_inc >= i2cm_pkg::RECOVERY_PULSES) begin
            scl_d = 1'b1; sda_d = 1'b0; phase_d = i2cm_pkg::PH_P_A;
          end else begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = i2cm_pkg::PH_V_H;
          end
        end
        default: phase_d = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.ready_res = (phase_d == i2cm_pkg::PH_IDLE);
    res_o.done_res  = done_d;
    res_o.rd_data   = rd_hold_d;
    res_o.ack_fail  = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cm_pkg::PH_IDLE;
      bit_cnt_q    <= 4'd0;
      shift_q      <= 8'h00;
      delay_q      <= 16'd0;
      tmo_q        <= 16'd0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      nack_q       <= 1'b0;
      rd_hold_q    <= 8'h00;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      tmo_q        <= tmo_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      nack_q       <= nack_d;
      rd_hold_q    <= rd_hold_d;
    end
  end

endmodule

// ===== design/i2cm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top level's ports.
module i2cm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [15:0] s_axis_tdata,
  input logic [3:0]  s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("request changed while waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A finishing command always leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
    else $error("done without ready");

  // A ready receiver never back-pressures the request side
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("request side stalled while result side ready");

  // Half period register reads back what was written
  a_cfg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] |=>
      paddr[2] || (prdata[15:0] == $past(pwdata[15:0])))
    else $error("half period readback mismatch");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
